FILE: rtl/core/jths_pkg.sv
// Package for the JTAG TAP host sequencer: opcodes, step modes and TAP state tables.
package jths_pkg;

	localparam int STATE_W      = 4;
	localparam int RESET_PULSES = 5;
	localparam int ROUTE_LIMIT  = 16;

	localparam logic [1:0] OP_GOTO  = 2'd0;
	localparam logic [1:0] OP_SHIFT = 2'd1;
	localparam logic [1:0] OP_IDLE  = 2'd2;

	localparam logic [STATE_W-1:0] TAP_RESET = 4'd0;

	typedef logic [STATE_W-1:0] tap_state_t;

	typedef enum logic [2:0] {
		MODE_NONE  = 3'd0,
		MODE_RESET = 3'd1,
		MODE_ROUTE = 3'd2,
		MODE_SHIFT = 3'd3,
		MODE_IDLE  = 3'd4
	} mode_t;

	// TAP next state for a given TMS level.
	function automatic tap_state_t tap_next(input tap_state_t s, input logic tms);
		tap_state_t lo;
		tap_state_t hi;
		case (s)
			4'd0:    begin lo = 4'd1;  hi = 4'd0;  end
			4'd1:    begin lo = 4'd1;  hi = 4'd2;  end
			4'd2:    begin lo = 4'd3;  hi = 4'd9;  end
			4'd3:    begin lo = 4'd4;  hi = 4'd5;  end
			4'd4:    begin lo = 4'd4;  hi = 4'd5;  end
			4'd5:    begin lo = 4'd6;  hi = 4'd8;  end
			4'd6:    begin lo = 4'd6;  hi = 4'd7;  end
			4'd7:    begin lo = 4'd4;  hi = 4'd8;  end
			4'd8:    begin lo = 4'd1;  hi = 4'd2;  end
			4'd9:    begin lo = 4'd10; hi = 4'd0;  end
			4'd10:   begin lo = 4'd11; hi = 4'd12; end
			4'd11:   begin lo = 4'd11; hi = 4'd12; end
			4'd12:   begin lo = 4'd13; hi = 4'd15; end
			4'd13:   begin lo = 4'd13; hi = 4'd14; end
			4'd14:   begin lo = 4'd11; hi = 4'd15; end
			4'd15:   begin lo = 4'd1;  hi = 4'd2;  end
			default: begin lo = 4'd0;  hi = 4'd0;  end
		endcase
		return tms ? hi : lo;
	endfunction

	// Bit t of the entry for state s is the TMS level that moves from s toward t.
	function automatic logic [15:0] route_mask(input tap_state_t s);
		logic [15:0] m;
		case (s)
			4'd0:    m = 16'h0001;
			4'd1:    m = 16'hFFFD;
			4'd2:    m = 16'hFE03;
			4'd3:    m = 16'hFFE7;
			4'd4:    m = 16'hFFEF;
			4'd5:    m = 16'hFF0F;
			4'd6:    m = 16'hFFBF;
			4'd7:    m = 16'hFF0F;
			4'd8:    m = 16'hFEFD;
			4'd9:    m = 16'h01FF;
			4'd10:   m = 16'hF3FF;
			4'd11:   m = 16'hF7FF;
			4'd12:   m = 16'h87FF;
			4'd13:   m = 16'hDFFF;
			4'd14:   m = 16'h87FF;
			4'd15:   m = 16'h7FFD;
			default: m = 16'h0000;
		endcase
		return m;
	endfunction

endpackage

FILE: rtl/core/jtag_tap_host_sequencer.sv
// A transaction is taken only when idle; the sequencer then enters its run state and loads
// each result into the output register, one result per cycle from the step unit, stalled
// while the output register is held. A new transaction waits until the last result is loaded.
// Reset (arst_n low, asynchronous) puts the tracked TAP state at test-logic-reset,
// clears the held TMS level and drops any pending result.
module jtag_tap_host_sequencer #(
	parameter int MAX_PULSES = 64
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [1:0]             operation,
	input  jths_pkg::tap_state_t   target_state,
	input  logic                   tdi_bit,
	input  logic                   last_bit,
	input  logic                   exit_on_last,
	input  logic                   tdo_level,
	input  logic [6:0]             pulse_count,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic                   pulse,
	output logic                   tms_level,
	output logic                   tdi_level,
	output logic                   tdo_captured,
	output jths_pkg::tap_state_t   tap_state_after,
	output logic                   last
);
	import jths_pkg::*;

	// Remaining-step counter must hold MAX_PULSES and the route limit.
	localparam int CLOG_W = $clog2(MAX_PULSES + 1);
	localparam int CNT_W  = (CLOG_W > 5) ? CLOG_W : 5;
	localparam logic [6:0] MAX_P7 = 7'(MAX_PULSES);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_RUN  = 2'b10
	} seq_state_t;

	seq_state_t         state_q;
	mode_t              mode_q;
	tap_state_t         tap_state_q;
	logic               tms_held_q;
	tap_state_t         target_q;
	logic               tdi_q;
	logic               tdo_q;
	logic               exit_q;
	logic [CNT_W-1:0]   remain_q;

	logic               out_valid_q;
	logic               pulse_q;
	logic               tms_q;
	logic               tdi_out_q;
	logic               tdo_out_q;
	tap_state_t         tap_after_q;
	logic               last_q;

	// Accept side: decide the step mode and the step count for the new transaction.
	logic               accept;
	logic [6:0]         idle_sat;
	mode_t              new_mode;
	logic [CNT_W-1:0]   new_remain;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;
	assign idle_sat = (pulse_count > MAX_P7) ? MAX_P7 : pulse_count;

	always_comb begin
		new_mode   = MODE_NONE;
		new_remain = CNT_W'(1);
		case (operation)
			OP_GOTO: begin
				if (target_state == TAP_RESET) begin
					new_mode   = MODE_RESET;
					new_remain = CNT_W'(RESET_PULSES);
				end else if (target_state != tap_state_q) begin
					new_mode   = MODE_ROUTE;
					new_remain = CNT_W'(ROUTE_LIMIT);
				end
			end
			OP_SHIFT: begin
				new_mode = MODE_SHIFT;
			end
			OP_IDLE: begin
				if (idle_sat != 7'd0) begin
					new_mode   = MODE_IDLE;
					new_remain = CNT_W'(idle_sat);
				end
			end
			default: begin
				new_mode = MODE_NONE;
			end
		endcase
	end

	// Step unit: one TCK pulse per step except in no-op mode. The next-state lookup moves
	// the tracked TAP state; the mode picks the TMS level and whether the state advances.
	logic               emit;
	logic               step_tms;
	logic               step_adv;
	logic               step_last;
	logic               step_done;
	logic               remain_one;
	logic [15:0]        mask_row;
	tap_state_t         step_next;

	assign emit       = (state_q == ST_RUN) && (!out_valid_q || out_ready);
	assign remain_one = (remain_q == CNT_W'(1));
	assign mask_row   = route_mask(tap_state_q);
	assign step_next  = step_adv ? tap_next(tap_state_q, step_tms) : tap_state_q;

	always_comb begin
		step_tms  = tms_held_q;
		step_adv  = 1'b0;
		step_last = 1'b1;
		step_done = 1'b1;
		case (mode_q)
			MODE_RESET: begin
				step_tms  = 1'b1;
				step_adv  = 1'b1;
				step_last = remain_one;
				step_done = remain_one;
			end
			MODE_ROUTE: begin
				step_tms  = mask_row[target_q];
				step_adv  = 1'b1;
				// Stop at the target, or give up after the route limit without a last mark.
				step_last = (tap_next(tap_state_q, mask_row[target_q]) == target_q);
				step_done = step_last || remain_one;
			end
			MODE_SHIFT: begin
				// Raise TMS only on a final bit that asks to leave the shift state.
				if (exit_q) begin
					step_tms = 1'b1;
					step_adv = 1'b1;
				end
			end
			MODE_IDLE: begin
				step_last = remain_one;
				step_done = remain_one;
			end
			default: begin
				step_last = 1'b1;
				step_done = 1'b1;
			end
		endcase
	end

	// Sequencer control and tracked TAP state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			tap_state_q <= TAP_RESET;
			tms_held_q  <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_RUN;
					end
				end
				ST_RUN: begin
					if (emit && step_done) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			if (emit && step_adv) begin
				tap_state_q <= step_next;
				tms_held_q  <= step_tms;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Transaction payload and step counter.
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q   <= new_mode;
			remain_q <= new_remain;
			target_q <= target_state;
			tdi_q    <= tdi_bit;
			tdo_q    <= tdo_level;
			exit_q   <= last_bit && exit_on_last;
		end else if (emit) begin
			remain_q <= remain_q - CNT_W'(1);
		end
	end

	// Output register: hold the result until the consumer takes it.
	always_ff @(posedge clk) begin
		if (emit) begin
			pulse_q     <= (mode_q != MODE_NONE);
			tms_q       <= step_tms;
			tdi_out_q   <= (mode_q == MODE_SHIFT) ? tdi_q : 1'b0;
			tdo_out_q   <= (mode_q == MODE_SHIFT) ? tdo_q : 1'b0;
			tap_after_q <= step_next;
			last_q      <= step_last;
		end
	end

	assign out_valid       = out_valid_q;
	assign pulse           = pulse_q;
	assign tms_level       = tms_q;
	assign tdi_level       = tdi_out_q;
	assign tdo_captured    = tdo_out_q;
	assign tap_state_after = tap_after_q;
	assign last            = last_q;

`ifndef SYNTH
	// A pending result always reports the current tracked TAP state.
	a_after_matches: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> (tap_after_q == tap_state_q))
		else $error("pending result disagrees with tracked TAP state");

	// A no-pulse result is always the final result of its transaction.
	a_nopulse_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !pulse_q) |-> last_q)
		else $error("no-pulse result not marked last");

	// The tracked state moves only together with a freshly loaded pulse result.
	a_state_moves: assert property (@(posedge clk) disable iff (!arst_n)
		(tap_state_q != $past(tap_state_q)) |-> (out_valid_q && pulse_q))
		else $error("TAP state changed without a pulse");

	// An accepted transaction always blocks the next one in the cycle after the accept.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !in_ready)
		else $error("sequencer ready right after accepting a transaction");
`endif

endmodule

FILE: dv/jths_tb_pkg.sv
// TAP tables, pulse record type and the expected-pulse scoreboard for the sequencer bench.
package jths_tb_pkg;
	import jths_pkg::*;

	localparam logic [1:0] OP_RESERVED = 2'd3;
	localparam int         IDLE_CAP    = 64;

	localparam tap_state_t TAP_IDLE  = 4'd1;
	localparam tap_state_t SHIFT_DR  = 4'd4;
	localparam tap_state_t PAUSE_DR  = 4'd6;
	localparam tap_state_t EXIT2_DR  = 4'd7;
	localparam tap_state_t SELECT_IR = 4'd9;
	localparam tap_state_t SHIFT_IR  = 4'd11;
	localparam tap_state_t PAUSE_IR  = 4'd13;
	localparam tap_state_t UPDATE_IR = 4'd15;

	typedef struct packed {
		logic       pulse;
		logic       tms;
		logic       tdi;
		logic       tdo;
		tap_state_t state;
		logic       last;
	} pulse_rec_t;

	localparam tap_state_t STEP_TMS_LOW [16] = '{
		4'd1, 4'd1, 4'd3, 4'd4, 4'd4, 4'd6, 4'd6, 4'd4,
		4'd1, 4'd10, 4'd11, 4'd11, 4'd13, 4'd13, 4'd11, 4'd1
	};
	localparam tap_state_t STEP_TMS_HIGH [16] = '{
		4'd0, 4'd2, 4'd9, 4'd5, 4'd5, 4'd8, 4'd7, 4'd8,
		4'd2, 4'd0, 4'd12, 4'd12, 4'd15, 4'd14, 4'd15, 4'd2
	};
	// bit t of entry s: TMS level that heads from s toward t
	localparam logic [15:0] TMS_TOWARD [16] = '{
		16'h0001, 16'hFFFD, 16'hFE03, 16'hFFE7, 16'hFFEF, 16'hFF0F, 16'hFFBF, 16'hFF0F,
		16'hFEFD, 16'h01FF, 16'hF3FF, 16'hF7FF, 16'h87FF, 16'hDFFF, 16'h87FF, 16'h7FFD
	};

	class tap_walk_scoreboard;
		tap_state_t tap_now;
		logic       tms_now;
		pulse_rec_t due_q[$];
		int         errors;

		function new();
			tap_now = TAP_RESET;
			tms_now = 1'b0;
			errors  = 0;
		endfunction

		function int pending();
			return due_q.size();
		endfunction

		function void clock_tap(logic tms);
			tap_now = tms ? STEP_TMS_HIGH[tap_now] : STEP_TMS_LOW[tap_now];
			tms_now = tms;
		endfunction

		function void push_pulse(logic pulse, logic tms, logic tdi, logic tdo, logic last);
			pulse_rec_t r;
			r.pulse = pulse;
			r.tms   = tms;
			r.tdi   = tdi;
			r.tdo   = tdo;
			r.state = tap_now;
			r.last  = last;
			due_q.push_back(r);
		endfunction

		// Work out every pulse one accepted request produces.
		function void note_request(logic [1:0] op, tap_state_t tgt, logic tdi, logic last_bit,
				logic exit_last, logic tdo, logic [6:0] count);
			int   n;
			int   i;
			int   reps;
			logic tms;
			n = 0;
			case (op)
				OP_GOTO: begin
					if (tgt == TAP_RESET) begin
						for (i = 0; i < RESET_PULSES; i++) begin
							clock_tap(1'b1);
							push_pulse(1'b1, 1'b1, 1'b0, 1'b0, i == RESET_PULSES - 1);
							n++;
						end
					end else begin
						while (tap_now != tgt && n < ROUTE_LIMIT) begin
							tms = TMS_TOWARD[tap_now][tgt];
							clock_tap(tms);
							push_pulse(1'b1, tms, 1'b0, 1'b0, tap_now == tgt);
							n++;
						end
					end
				end
				OP_SHIFT: begin
					tms = tms_now;
					if (last_bit && exit_last) begin
						tms = 1'b1;
						clock_tap(1'b1);
					end
					push_pulse(1'b1, tms, tdi, tdo, 1'b1);
					n++;
				end
				OP_IDLE: begin
					reps = (count > IDLE_CAP) ? IDLE_CAP : int'(count);
					for (i = 0; i < reps; i++) begin
						push_pulse(1'b1, tms_now, 1'b0, 1'b0, i + 1 == reps);
						n++;
					end
				end
				default: ;
			endcase
			if (n == 0)
				push_pulse(1'b0, tms_now, 1'b0, 1'b0, 1'b1);
		endfunction

		function void compare(string field, int expd, int got);
			if (expd != got) begin
				errors++;
				$error("%s mismatch: expected %0d, actual %0d", field, expd, got);
			end
		endfunction

		function void check_pulse(pulse_rec_t got);
			pulse_rec_t expd;
			if (due_q.size() == 0) begin
				errors++;
				$error("unexpected result: pulse %0d tms %0d tap_state_after %0d last %0d",
					got.pulse, got.tms, got.state, got.last);
				return;
			end
			expd = due_q.pop_front();
			compare("pulse", expd.pulse, got.pulse);
			compare("tms_level", expd.tms, got.tms);
			compare("tdi_level", expd.tdi, got.tdi);
			compare("tdo_captured", expd.tdo, got.tdo);
			compare("tap_state_after", expd.state, got.state);
			compare("last", expd.last, got.last);
		endfunction
	endclass

endpackage

FILE: dv/tb_jtag_tap_host_sequencer.sv
// Self-checking bench for the JTAG TAP host sequencer: directed and random requests.
module tb_jtag_tap_host_sequencer;
	import jths_pkg::*;
	import jths_tb_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int HOLD_CYCLES   = 200;
	localparam int SETTLE_CYCLES = 20;
	localparam int PHASE_ITEMS   = 34;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [1:0] operation;
	tap_state_t target_state;
	logic       tdi_bit;
	logic       last_bit;
	logic       exit_on_last;
	logic       tdo_level;
	logic [6:0] pulse_count;
	logic       out_valid;
	logic       out_ready;
	logic       pulse;
	logic       tms_level;
	logic       tdi_level;
	logic       tdo_captured;
	tap_state_t tap_state_after;
	logic       last;

	int          send_idle_pct;
	int          recv_idle_pct;
	int          hold_requests;
	int          hold_seen;
	int          hold_left;
	int          items_sent;
	int unsigned cycle_count;

	tap_walk_scoreboard walk_sb;

	jtag_tap_host_sequencer #(
		.MAX_PULSES(IDLE_CAP)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.operation(operation),
		.target_state(target_state),
		.tdi_bit(tdi_bit),
		.last_bit(last_bit),
		.exit_on_last(exit_on_last),
		.tdo_level(tdo_level),
		.pulse_count(pulse_count),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.pulse(pulse),
		.tms_level(tms_level),
		.tdi_level(tdi_level),
		.tdo_captured(tdo_captured),
		.tap_state_after(tap_state_after),
		.last(last)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Hard stop in case a handshake never completes.
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	// Receiver: stall at random, or hold off entirely for a long stretch when
	// the stimulus asks for it so the sequencer backs up into its input.
	initial begin
		hold_seen = 0;
		hold_left = 0;
	end
	always @(posedge clk) begin
		if (hold_requests != hold_seen) begin
			hold_seen = hold_requests;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	// Monitor both channels at the edge; all drives are nonblocking, so the
	// values seen here are the ones the sequencer sampled.
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready)
				walk_sb.note_request(operation, target_state, tdi_bit, last_bit,
					exit_on_last, tdo_level, pulse_count);
			if (out_valid && out_ready)
				walk_sb.check_pulse('{pulse, tms_level, tdi_level, tdo_captured,
					tap_state_after, last});
		end
	end

	// Offer one request transaction and hold it until it is taken.
	task automatic offer_request(input logic [1:0] op, input tap_state_t tgt,
			input logic tdi, input logic lb, input logic ex, input logic tdo,
			input logic [6:0] cnt);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid     <= 1'b1;
		operation    <= op;
		target_state <= tgt;
		tdi_bit      <= tdi;
		last_bit     <= lb;
		exit_on_last <= ex;
		tdo_level    <= tdo;
		pulse_count  <= cnt;
		do @(posedge clk); while (!in_ready);
		items_sent++;
	endtask

	// Drop valid and wait until every predicted pulse has come back.
	task automatic wait_drained();
		in_valid <= 1'b0;
		@(posedge clk);
		while (walk_sb.pending() != 0)
			@(posedge clk);
	endtask

	// Well-formed scan: enter a shift state, clock a short run of bits, then move on.
	task automatic send_shift_run();
		int nbits;
		int i;
		logic fin;
		nbits = $urandom_range(8, 1);
		offer_request(OP_GOTO, $urandom_range(1) ? SHIFT_IR : SHIFT_DR,
			1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom), 7'($urandom));
		for (i = 0; i < nbits; i++) begin
			fin = (i == nbits - 1);
			offer_request(OP_SHIFT, 4'($urandom), 1'($urandom), fin,
				fin ? ($urandom_range(3) != 0) : 1'($urandom_range(1)), 1'($urandom),
				7'($urandom));
		end
		if ($urandom_range(1))
			offer_request(OP_GOTO, 4'($urandom_range(15)), 1'($urandom), 1'($urandom),
				1'($urandom), 1'($urandom), 7'($urandom));
		else
			offer_request(OP_IDLE, 4'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
				1'($urandom), 7'($urandom_range(6)));
	endtask

	// Noise: any operation, any fields; idle counts mostly short.
	task automatic send_noise();
		logic [6:0] cnt;
		cnt = ($urandom_range(9) == 0) ? 7'($urandom_range(127)) : 7'($urandom_range(10));
		offer_request(2'($urandom_range(3)), 4'($urandom_range(15)), 1'($urandom),
			1'($urandom), 1'($urandom), 1'($urandom), cnt);
	endtask

	initial begin
		int phase;
		int phase_end;
		walk_sb       = new();
		arst_n        = 1'b0;
		in_valid      = 1'b0;
		operation     = OP_GOTO;
		target_state  = TAP_RESET;
		tdi_bit       = 1'b0;
		last_bit      = 1'b0;
		exit_on_last  = 1'b0;
		tdo_level     = 1'b0;
		pulse_count   = '0;
		out_ready     = 1'b0;
		send_idle_pct = 34;
		recv_idle_pct = 83;
		hold_requests = 0;
		items_sent    = 0;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: reset walk from reset, zero and saturated idles, already at target,
		// shift bits with and without exit, a reserved opcode, routes through both columns.
		offer_request(OP_GOTO, TAP_RESET, 1'b1, 1'b1, 1'b1, 1'b1, 7'h7F);
		offer_request(OP_IDLE, TAP_RESET, 1'b0, 1'b0, 1'b0, 1'b0, 7'd0);
		offer_request(OP_GOTO, TAP_IDLE, 1'b0, 1'b0, 1'b0, 1'b0, 7'd0);
		offer_request(OP_GOTO, TAP_IDLE, 1'b1, 1'b1, 1'b1, 1'b1, 7'd3);
		offer_request(OP_IDLE, TAP_RESET, 1'b0, 1'b0, 1'b0, 1'b0, 7'd1);
		offer_request(OP_GOTO, SHIFT_DR, 1'b0, 1'b0, 1'b0, 1'b0, 7'd0);
		offer_request(OP_SHIFT, TAP_RESET, 1'b1, 1'b0, 1'b1, 1'b0, 7'd0);
		offer_request(OP_SHIFT, TAP_RESET, 1'b0, 1'b1, 1'b0, 1'b1, 7'd0);
		offer_request(OP_SHIFT, UPDATE_IR, 1'b1, 1'b1, 1'b1, 1'b1, 7'h7F);
		offer_request(OP_GOTO, PAUSE_DR, 1'b0, 1'b0, 1'b0, 1'b0, 7'd0);
		offer_request(OP_GOTO, EXIT2_DR, 1'b0, 1'b0, 1'b0, 1'b0, 7'd0);
		offer_request(OP_IDLE, TAP_RESET, 1'b0, 1'b0, 1'b0, 1'b0, 7'(IDLE_CAP));
		offer_request(OP_GOTO, SHIFT_IR, 1'b0, 1'b0, 1'b0, 1'b0, 7'd0);
		offer_request(OP_SHIFT, TAP_RESET, 1'b0, 1'b1, 1'b1, 1'b0, 7'd0);
		offer_request(OP_GOTO, PAUSE_IR, 1'b0, 1'b0, 1'b0, 1'b0, 7'd0);
		offer_request(OP_GOTO, UPDATE_IR, 1'b0, 1'b0, 1'b0, 1'b0, 7'd0);
		offer_request(OP_IDLE, TAP_RESET, 1'b0, 1'b0, 1'b0, 1'b0, 7'h7F);
		offer_request(OP_RESERVED, UPDATE_IR, 1'b1, 1'b1, 1'b1, 1'b1, 7'h7F);
		offer_request(OP_GOTO, SELECT_IR, 1'b0, 1'b0, 1'b0, 1'b0, 7'd0);
		offer_request(OP_IDLE, TAP_RESET, 1'b0, 1'b0, 1'b0, 1'b0, 7'(IDLE_CAP + 1));
		offer_request(OP_GOTO, TAP_RESET, 1'b0, 1'b0, 1'b0, 1'b0, 7'd0);
		wait_drained();

		// Random: receiver-idle heavy first, then swapped, then no idling at all.
		// The last phase opens with a long receiver hold-off while requests keep coming.
		for (phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin send_idle_pct = 34; recv_idle_pct = 83; end
				1: begin send_idle_pct = 83; recv_idle_pct = 34; end
				default: begin send_idle_pct = 0; recv_idle_pct = 0; end
			endcase
			if (phase == 2)
				hold_requests++;
			phase_end = items_sent + PHASE_ITEMS;
			while (items_sent < phase_end) begin
				if ($urandom_range(99) < 70)
					send_shift_run();
				else
					send_noise();
				if ($urandom_range(30) == 0)
					wait_drained();
			end
			wait_drained();
		end

		// Let any stray result show up before judging.
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (walk_sb.errors == 0 && walk_sb.pending() == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
